// ===== rtl/b2r_pkg.sv =====
`timescale 1ns / 1ps

package b2r_pkg;

    localparam int unsigned VALUE_W  = 12;
    localparam int unsigned SYMBOL_W = 7;
    localparam int unsigned GROUPS   = 13;
    localparam int unsigned GRP_W    = 4;

    // largest value that has a numeral
    localparam logic [VALUE_W-1:0] MAX_ROMAN = 12'd3999;

    // ascii codes
    localparam logic [SYMBOL_W-1:0] SYM_NONE = 7'h00;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 7'h49;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 7'h56;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 7'h58;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 7'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 7'h43;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 7'h44;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 7'h4D;

    // symbol groups, largest weight first
    localparam logic [VALUE_W-1:0] GRP_WEIGHT [GROUPS] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    localparam logic [SYMBOL_W-1:0] GRP_FIRST [GROUPS] = '{
        SYM_M, SYM_C, SYM_D, SYM_C, SYM_C, SYM_X, SYM_L,
        SYM_X, SYM_X, SYM_I, SYM_V, SYM_I, SYM_I
    };

    // SYM_NONE for a single-symbol group
    localparam logic [SYMBOL_W-1:0] GRP_SECOND [GROUPS] = '{
        SYM_NONE, SYM_M, SYM_NONE, SYM_D, SYM_NONE, SYM_C, SYM_NONE,
        SYM_L, SYM_NONE, SYM_X, SYM_NONE, SYM_V, SYM_NONE
    };

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_b2r_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_b2r_cmd;

    // datapath to controller
    typedef struct packed {
        logic slot_free;
        logic beat_last;
    } t_b2r_stat;

    // index of the largest group weight not above the remainder
    function automatic logic [GRP_W-1:0] pick_group(input logic [VALUE_W-1:0] rest);
        logic [GRP_W-1:0] idx;
        idx = GRP_W'(GROUPS - 1);
        for (int k = GROUPS - 1; k >= 0; k--) begin
            if (rest >= GRP_WEIGHT[k]) begin
                idx = GRP_W'(k);
            end
        end
        return idx;
    endfunction

endpackage

// ===== rtl/b2r_ctrl.sv =====
`timescale 1ns / 1ps

module b2r_ctrl
    import b2r_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_b2r_stat i_stat,
    output t_b2r_cmd  o_cmd
);

    t_b2r_state r_state;
    t_b2r_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.slot_free && i_stat.beat_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_RUN: begin
                o_cmd.step = i_stat.slot_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/b2r_datapath.sv =====
`timescale 1ns / 1ps

module b2r_datapath
    import b2r_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_b2r_cmd            i_cmd,
    output t_b2r_stat           o_stat,
    input  logic [VALUE_W-1:0]  i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [SYMBOL_W-1:0] o_symbol,
    output logic                o_last,
    output logic                o_error
);

    logic [VALUE_W-1:0]  r_rest;
    logic [VALUE_W-1:0]  n_rest;
    logic                r_err;
    logic                r_pend;
    logic                n_pend;
    logic [SYMBOL_W-1:0] r_second;
    logic                r_o_valid;
    logic [SYMBOL_W-1:0] r_o_sym;
    logic [SYMBOL_W-1:0] n_o_sym;
    logic                r_o_last;
    logic                r_o_err;

    logic [GRP_W-1:0]    w_grp;
    logic [VALUE_W-1:0]  w_sub;
    logic                w_has_second;
    logic                w_last;

    // greedy group choice and remainder
    assign w_grp        = pick_group(r_rest);
    assign w_sub        = r_rest - GRP_WEIGHT[w_grp];
    assign w_has_second = (GRP_SECOND[w_grp] != SYM_NONE);

    // symbol of the next beat and whether it closes the numeral
    always_comb begin
        n_rest  = r_rest;
        n_pend  = 1'b0;
        n_o_sym = SYM_NONE;
        w_last  = 1'b1;
        if (r_err) begin
            w_last = 1'b1;
        end else if (r_pend) begin
            n_o_sym = r_second;
            w_last  = (r_rest == '0);
        end else begin
            n_o_sym = GRP_FIRST[w_grp];
            n_rest  = w_sub;
            n_pend  = w_has_second;
            w_last  = !w_has_second && (w_sub == '0);
        end
    end

    assign o_stat.slot_free = !r_o_valid || i_ready;
    assign o_stat.beat_last = w_last;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest <= i_value;
            r_err  <= (i_value == '0) || (i_value > MAX_ROMAN);
        end else if (i_cmd.step) begin
            r_rest   <= n_rest;
            r_second <= GRP_SECOND[w_grp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (i_cmd.load) begin
            r_pend <= 1'b0;
        end else if (i_cmd.step) begin
            r_pend <= n_pend;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_o_sym  <= n_o_sym;
            r_o_last <= w_last;
            r_o_err  <= r_err;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_symbol = r_o_sym;
    assign o_last   = r_o_last;
    assign o_error  = r_o_err;

endmodule

// ===== rtl/binary_to_roman_numeral.sv =====
`timescale 1ns / 1ps

// Binary to Roman numeral converter. Each input beat carries a 12-bit value;
// the block answers with its Roman numeral as ASCII characters, most
// significant first, one character per output beat, tlast on the final one.
// Subtractive pairs (IV, IX, XL, XC, CD, CM) are used. A value of zero or
// above 3999 gives one beat with symbol 0, tlast set and tuser (error) set.
// Timing: the value is loaded into a working register, then the block gives
// one character per cycle while the sink is ready. The longest numeral is
// 3888 = MMMDCCCLXXXVIII. The character rate is set by the single output
// register; a new value is taken once the last character is in that register.

module binary_to_roman_numeral
    import b2r_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] value, [15:12] zero
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [6:0] symbol, [7] zero
    output logic       o_m_tlast,
    output logic       o_m_tuser     // [0] error
);

    t_b2r_cmd            w_cmd;
    t_b2r_stat           w_stat;
    logic [SYMBOL_W-1:0] w_symbol;

    b2r_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    b2r_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_value  (i_s_tdata[VALUE_W-1:0]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_symbol (w_symbol),
        .o_last   (o_m_tlast),
        .o_error  (o_m_tuser)
    );

    assign o_m_tdata = {1'b0, w_symbol};

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import b2r_pkg::*;

    localparam int unsigned IDLE_LIMIT = 1000;
    localparam int unsigned RANDOM_ITEMS = 195;

    // one character of a numeral as it appears on the output stream
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } t_roman_char;

    // expected numeral characters, in order of arrival
    class roman_scoreboard;
        t_roman_char expected_chars[$];
        int          fails;

        function new();
            fails = 0;
        endfunction

        // one decimal digit spelled with its unit, five and ten symbols
        function void add_digit(ref logic [SYMBOL_W-1:0] run[$], input int digit,
                                input logic [SYMBOL_W-1:0] one,
                                input logic [SYMBOL_W-1:0] five,
                                input logic [SYMBOL_W-1:0] ten);
            if (digit == 9) begin
                run.push_back(one);
                run.push_back(ten);
            end else if (digit == 4) begin
                run.push_back(one);
                run.push_back(five);
            end else begin
                if (digit >= 5) begin
                    run.push_back(five);
                end
                repeat (digit % 5) run.push_back(one);
            end
        endfunction

        // work out the characters that an accepted value must produce
        function void note_value(logic [VALUE_W-1:0] value);
            logic [SYMBOL_W-1:0] run[$];
            t_roman_char         ch;
            int                  n;
            if (value == '0 || value > MAX_ROMAN) begin
                ch.symbol = SYM_NONE;
                ch.last   = 1'b1;
                ch.error  = 1'b1;
                expected_chars.push_back(ch);
                return;
            end
            n = int'(value);
            add_digit(run, n / 1000, SYM_M, SYM_NONE, SYM_NONE);
            add_digit(run, (n / 100) % 10, SYM_C, SYM_D, SYM_M);
            add_digit(run, (n / 10) % 10, SYM_X, SYM_L, SYM_C);
            add_digit(run, n % 10, SYM_I, SYM_V, SYM_X);
            foreach (run[k]) begin
                ch.symbol = run[k];
                ch.last   = (k == run.size() - 1);
                ch.error  = 1'b0;
                expected_chars.push_back(ch);
            end
        endfunction

        // compare one output beat with the oldest expected character
        function void check_char(logic [SYMBOL_W-1:0] symbol, logic last, logic error);
            t_roman_char want;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected beat symbol=%h last=%b error=%b",
                         $time, symbol, last, error);
                fails++;
                return;
            end
            want = expected_chars.pop_front();
            if (want.symbol !== symbol) begin
                $display("%0t: symbol expected %h actual %h", $time, want.symbol, symbol);
                fails++;
            end
            if (want.last !== last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, last);
                fails++;
            end
            if (want.error !== error) begin
                $display("%0t: error expected %b actual %b", $time, want.error, error);
                fails++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;     // [11:0] value, [15:12] zero
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [7:0]  o_m_tdata;     // [6:0] symbol, [7] zero
    logic        o_m_tlast;
    logic        o_m_tuser;     // [0] error

    roman_scoreboard board;
    bit              send_burst;
    bit              sink_burst;
    int unsigned     idle_cycles;

    binary_to_roman_numeral i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // offer one value after a random gap and wait for its beat to be taken
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0000, value};
        do @(posedge i_clk); while (!o_s_tready);
        board.note_value(value);
    endtask

    // random value, mostly convertible, some out of range, some short numerals
    function automatic logic [VALUE_W-1:0] draw_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            return '0;
        end else if (pick < 10) begin
            return VALUE_W'($urandom_range(4000, 4095));
        end else if (pick < 25) begin
            return VALUE_W'($urandom_range(1, 50));
        end else if (pick < 40) begin
            return VALUE_W'($urandom_range(3000, 3999));
        end
        return VALUE_W'($urandom_range(1, 3999));
    endfunction

    // stimulus and end of run
    initial begin
        logic [VALUE_W-1:0] directed[$];
        board      = new();
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        send_burst = 1'b0;
        directed = {12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd14, 12'd40,
                    12'd49, 12'd90, 12'd99, 12'd400, 12'd444, 12'd900, 12'd999,
                    12'd1000, 12'd1994, 12'd3888, 12'd3999, 12'd4000, 12'd4095,
                    12'd2048, 12'd1365, 12'd2730, 12'd3000};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // edges of the range, every subtractive pair, error values
        foreach (directed[k]) begin
            send_value(directed[k]);
        end

        // random values with stretches of back-to-back beats
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
            end
            send_value(draw_value());
        end
        i_s_tvalid <= 1'b0;

        // drain, then wait a while for stray beats
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.fails == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // sink with random stalls per beat
    initial begin
        int stall;
        int beats;
        i_m_tready <= 1'b0;
        beats = 0;
        sink_burst = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (beats % 40 == 0) begin
                sink_burst = ($urandom_range(0, 3) == 0);
            end
            stall = sink_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_char(o_m_tdata[SYMBOL_W-1:0], o_m_tlast, o_m_tuser);
            beats++;
        end
    end

    // watchdog on cycles with no beat taken on either side
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat taken for %0d cycles", $time, idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule

// ===== sim.f =====
rtl/b2r_pkg.sv
rtl/b2r_ctrl.sv
rtl/b2r_datapath.sv
rtl/binary_to_roman_numeral.sv
test/testbench.sv
